[rtl/core/crdl_pkg.sv]
// Shared types and constants for the configuration ROM directory lookup.
`timescale 1ns / 1ps
`default_nettype none

package crdl_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int HDR_LIMIT = 256;

  localparam logic [31:0] CSR_BASE_LO = 32'hF000_0000;
  localparam logic [31:0] ROM_BASE_LO = 32'hF000_0400;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOENT   = 2'd1;
  localparam logic [1:0] ST_BADARG  = 2'd2;
  localparam logic [1:0] ST_HDRLONG = 2'd3;

  localparam logic [1:0] KT_IMMEDIATE = 2'd0;
  localparam logic [1:0] KT_OFFSET    = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_HDR = 2'd0,
    CMD_LOAD_ENT = 2'd1,
    CMD_FIND     = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WAIT,
    FSM_SCAN,
    FSM_FINISH
  } fsm_state_t;

  typedef enum logic [1:0] {
    ASEL_NONE,
    ASEL_CSR,
    ASEL_ROM
  } addr_sel_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [1:0]       etype;
    logic [5:0]       ekey;
    logic [23:0]      evalue;
    logic [24:0]      offset;
    addr_sel_t        asel;
  } crdl_res_t;

endpackage

`default_nettype wire

[rtl/core/crdl_entry_eval.sv]
// Decodes one directory entry quadlet into the reported fields and, for leaf and directory entries, its ROM offset.
`timescale 1ns / 1ps
`default_nettype none

module crdl_entry_eval
  import crdl_pkg::*;
(
  input  wire logic [31:0]      word,
  input  wire logic [IDX_W-1:0] index,
  input  wire logic [7:0]       dir_start,
  output crdl_res_t             res
);

  logic [1:0]  etype;
  logic [23:0] evalue;

  assign etype  = word[31:30];
  assign evalue = word[23:0];

  always_comb begin
    res        = '0;
    res.index  = index;
    res.etype  = etype;
    res.ekey   = word[29:24];
    res.evalue = evalue;
    res.asel   = ASEL_NONE;
    if (etype == KT_IMMEDIATE) begin
      res.status = ST_BADARG;
    end else if (etype == KT_OFFSET) begin
      res.status = ST_OK;
      res.asel   = ASEL_CSR;
    end else begin
      // Leaf and directory entries point relative to the entry's own position.
      res.status = ST_OK;
      res.asel   = ASEL_ROM;
      res.offset = 25'(evalue) + 25'(dir_start) + 25'(index) + 25'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/core/config_rom_directory_lookup.sv]
// Top level: directory store, key scan sequencer and result register.
// Flow: a load or an out-of-range query goes from idle straight to the finish
// state; an in-range query passes through the wait state for its memory read;
// a find scans the entries from index 0 until the first match or the last
// entry, and a find on an empty directory goes straight to finish.
// Throughput: one command at a time; the find scan reads one entry per cycle
// from the directory memory. Synchronous reset clears the entry count,
// dir_start and the control state; directory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module config_rom_directory_lookup
  import crdl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // s_tdata, low bit up: word[31:0], index[39:32], key[45:40], use_type[46],
  // want_type[48:47], zero fill.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [55:0]  s_tdata,
  // s_tuser: cmd[1:0].
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, low bit up: status[1:0], found_index[9:2], entry_type[11:10],
  // entry_key[17:12], entry_value[41:18], address_lo[73:42],
  // rom_offset[98:74], zero fill.
  output logic [103:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata
);

  localparam int MEM_AW = $clog2(MAX_ENTRIES);

  fsm_state_t       state, state_next;
  logic [7:0]       dir_start;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] q_index;
  logic [5:0]       q_key;
  logic             q_use;
  logic [1:0]       q_want;
  crdl_res_t        res;
  crdl_res_t        cmd_res;
  crdl_res_t        eval_res;
  logic [IDX_W-1:0] eval_idx;

  logic [31:0]       dir_mem [0:MAX_ENTRIES-1];
  logic [31:0]       rd_data;
  logic [MEM_AW-1:0] rd_addr;
  logic              mem_we;

  cmd_t        in_cmd;
  logic [31:0] in_word;
  logic [7:0]  in_index;
  logic [5:0]  in_key;
  logic        in_use;
  logic [1:0]  in_want;
  logic [15:0] hdr_count;
  logic        s_accept;
  logic        idx_in_mem;
  logic        idx_in_dir;
  logic        hit;
  logic        scan_last;
  logic        load_out;
  logic [31:0] addr_lo;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_word   = s_tdata[31:0];
  assign in_index  = s_tdata[39:32];
  assign in_key    = s_tdata[45:40];
  assign in_use    = s_tdata[46];
  assign in_want   = s_tdata[48:47];
  assign hdr_count = in_word[31:16];
  assign s_accept  = s_tvalid && s_tready;

  assign idx_in_mem = 32'(in_index) < MAX_ENTRIES;
  assign idx_in_dir = idx_in_mem && (CNT_W'(in_index) < entry_count);

  assign hit = (rd_data[29:24] == q_key) && (!q_use || (rd_data[31:30] == q_want));
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) >= entry_count;

  assign eval_idx = (state == FSM_SCAN) ? scan_idx : q_index;

  crdl_entry_eval u_eval (
    .word      (rd_data),
    .index     (eval_idx),
    .dir_start (dir_start),
    .res       (eval_res)
  );

  // Directory memory: writes come only from load-entry commands in idle. Such a
  // load also reads the entry it writes and gets the old word, which no result uses.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[MEM_AW'(in_index)] <= in_word;
    end
    rd_data <= dir_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (s_accept) begin
          case (in_cmd)
            CMD_FIND:  state_next = (entry_count == '0) ? FSM_FINISH : FSM_SCAN;
            CMD_QUERY: state_next = idx_in_dir ? FSM_WAIT : FSM_FINISH;
            default:   state_next = FSM_FINISH;
          endcase
        end
      end
      FSM_WAIT: state_next = FSM_FINISH;
      FSM_SCAN: begin
        if (hit || scan_last) begin
          state_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (load_out) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    rd_addr  = MEM_AW'(scan_idx) + MEM_AW'(1);
    case (state)
      FSM_IDLE: begin
        s_tready = 1'b1;
        mem_we   = s_accept && (in_cmd == CMD_LOAD_ENT) && idx_in_mem;
        rd_addr  = (in_cmd == CMD_FIND) ? '0 : MEM_AW'(in_index);
      end
      FSM_FINISH: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_start <= '0;
    end else if (cfg_we) begin
      dir_start <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (s_accept && (in_cmd == CMD_LOAD_HDR)) begin
      if ((hdr_count > 16'(HDR_LIMIT)) || (32'(hdr_count) > MAX_ENTRIES)) begin
        entry_count <= '0;
      end else begin
        entry_count <= CNT_W'(hdr_count);
      end
    end
  end

  // Result of a command that needs no memory read; lookups start from it and
  // replace it once the queried or a matching entry has been read.
  always_comb begin
    cmd_res      = '0;
    cmd_res.asel = ASEL_NONE;
    case (in_cmd)
      CMD_LOAD_HDR: begin
        if ((hdr_count > 16'(HDR_LIMIT)) || (32'(hdr_count) > MAX_ENTRIES)) begin
          cmd_res.status = ST_HDRLONG;
        end else begin
          cmd_res.status = ST_OK;
        end
      end
      CMD_LOAD_ENT: begin
        cmd_res.index = in_index;
        if (idx_in_mem) begin
          cmd_res.status = ST_OK;
          cmd_res.etype  = in_word[31:30];
          cmd_res.ekey   = in_word[29:24];
          cmd_res.evalue = in_word[23:0];
        end else begin
          cmd_res.status = ST_BADARG;
        end
      end
      CMD_FIND: begin
        cmd_res.status = ST_NOENT;
      end
      default: begin
        cmd_res.status = ST_BADARG;
        cmd_res.index  = in_index;
      end
    endcase
  end

  // Command capture and result assembly.
  always_ff @(posedge clk) begin
    case (state)
      FSM_IDLE: begin
        if (s_accept) begin
          q_index  <= in_index;
          q_key    <= in_key;
          q_use    <= in_use;
          q_want   <= in_want;
          scan_idx <= '0;
          res      <= cmd_res;
        end
      end
      FSM_WAIT: begin
        res <= eval_res;
      end
      FSM_SCAN: begin
        if (hit) begin
          res <= eval_res;
        end else if (!scan_last) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (res.asel)
      ASEL_CSR: addr_lo = CSR_BASE_LO + {6'd0, res.evalue, 2'b00};
      ASEL_ROM: addr_lo = ROM_BASE_LO + {5'd0, res.offset, 2'b00};
      default:  addr_lo = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'd0, res.offset, addr_lo, res.evalue, res.ekey, res.etype,
                  res.index, res.status};
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= HDR_LIMIT)
    else $error("entry count above header limit");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN) |-> (CNT_W'(scan_idx) < entry_count))
    else $error("scan index outside the directory");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
    else $error("pending result overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state != FSM_IDLE))
    else $error("sequencer idle right after a command");

endmodule

`default_nettype wire
